// File: hw/rtl/tcphb_pkg.sv
// Shared types, constants and register indexes for the TCP/IPv4 frame header builder.
package tcphb_pkg;

   localparam int unsigned CSR_INDEX_WIDTH = 3;
   localparam int unsigned CSR_DATA_WIDTH  = 32;

   localparam int unsigned MIN_PAYLOAD = 8;
   localparam int unsigned MAX_PAYLOAD = 65535;

   localparam int unsigned COUNT_WIDTH      = 17;
   localparam int unsigned WORD_COUNT       = 7;
   localparam int unsigned WORD_INDEX_WIDTH = 3;
   localparam logic [WORD_INDEX_WIDTH-1:0] LAST_WORD = WORD_INDEX_WIDTH'(WORD_COUNT - 1);

   localparam logic [COUNT_WIDTH-1:0] BYTE_COUNT_CAP = 17'h1_0000;

   localparam logic [31:0] CLIENT_SEQ_RESET = 32'd1000;
   localparam logic [31:0] SERVER_SEQ_RESET = 32'd500000;

   localparam logic [39:0] MAC_PREFIX      = 40'h02_0000_0000;
   localparam logic [7:0]  MAC_CLIENT_LOW  = 8'h01;
   localparam logic [7:0]  MAC_SERVER_LOW  = 8'h02;
   localparam logic [15:0] ETHER_TYPE_IPV4 = 16'h0800;
   localparam logic [15:0] IP_VER_TOS      = 16'h4500;
   localparam logic [15:0] IP_FLAGS        = 16'h4000;
   localparam logic [15:0] IP_TTL_PROTO    = 16'h4006;
   localparam logic [15:0] IP_TOTAL_EXTRA  = 16'd40;
   localparam logic [15:0] TCP_PROTO       = 16'h0006;
   localparam logic [15:0] TCP_LEN_EXTRA   = 16'd20;
   localparam logic [15:0] TCP_OFF_FLAGS   = 16'h5018;
   localparam logic [15:0] TCP_WINDOW      = 16'hffff;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_CLIENT_ADDRESS   = 3'd0,
      CSR_SERVER_ADDRESS   = 3'd1,
      CSR_CLIENT_TCP_PORT  = 3'd2,
      CSR_SERVER_TCP_PORT  = 3'd3,
      CSR_CLIENT_SEQ_START = 3'd4,
      CSR_SERVER_SEQ_START = 3'd5,
      CSR_IDENT_START      = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic        rejected;
      logic        direction;
      logic [15:0] length;
      logic [15:0] payload_sum;
      logic [15:0] pad_word;
      logic [15:0] ident;
      logic [31:0] src_ip;
      logic [31:0] dst_ip;
      logic [15:0] src_tcp_port;
      logic [15:0] dst_tcp_port;
      logic [31:0] seq;
      logic [31:0] ack;
   } job_type;

endpackage

// File: hw/rtl/tcphb_channels.sv
// Valid/ready channel interfaces for payload bytes and header words.
interface tcphb_req_if;
   logic       valid;
   logic       ready;
   logic       to_client;
   logic [7:0] data_byte;
   logic       last_byte;

   modport source (output valid, output to_client, output data_byte, output last_byte,
                   input ready);
   modport sink (input valid, input to_client, input data_byte, input last_byte,
                 output ready);
endinterface

interface tcphb_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] header_word;
   logic        rejected;
   logic        word_last;

   modport source (output valid, output header_word, output rejected, output word_last,
                   input ready);
   modport sink (input valid, input header_word, input rejected, input word_last,
                 output ready);
endinterface

// File: hw/rtl/tcp_ipv4_frame_header_builder.sv
// Top level of the TCP/IPv4 frame header builder: settings, payload accumulation, counters.
//
// Payload bytes are taken one per cycle. The final byte of a packet is checked (length 8 to
// 65535, equal to the big-endian first word) and handed as a job to a three-stage header
// pipeline: raw checksum sums, fold and complement, then word output. A good packet yields
// seven 64-bit header transactions, one per cycle while the result channel is ready; a bad
// one yields a single rejected transaction. Sequence and identification counters advance
// when the final byte of a good packet is taken and no register is written in the same cycle,
// so the next packet streams in without a gap. The input stalls only while the job slot
// ahead of the checksum stage is still occupied, which a stalled result channel or packets shorter
// than seven bytes can cause. Writing a start register loads its counter at once.
module tcp_ipv4_frame_header_builder import tcphb_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   tcphb_req_if.sink                  req_channel,
   tcphb_rsp_if.source                rsp_channel,
   input  logic                       csr_write_enable,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_write_data
);

   function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
      logic [16:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[15:0] + {15'b0, s[16]};
   endfunction

   logic [31:0]            client_address_ff, server_address_ff;
   logic [15:0]            client_tcp_port_ff, server_tcp_port_ff;
   logic [31:0]            client_seq_ff, server_seq_ff;
   logic [15:0]            ident_ff;
   logic [COUNT_WIDTH-1:0] byte_count_ff, byte_count_in;
   logic [31:0]            lead_word_ff, lead_word_in;
   logic [15:0]            payload_sum_ff, payload_sum_in;
   logic [7:0]             pending_high_byte_ff, pending_high_byte_in;
   logic                   packet_direction_ff, packet_direction_in;

   logic    accept, job_valid, job_ready, length_bad;
   job_type job;

   assign accept = req_channel.valid && req_channel.ready;
   assign req_channel.ready = job_ready;

   assign packet_direction_in = (byte_count_ff == '0) ? req_channel.to_client
                                                      : packet_direction_ff;
   assign lead_word_in = (byte_count_ff < COUNT_WIDTH'(4))
                         ? {lead_word_ff[23:0], req_channel.data_byte} : lead_word_ff;
   assign pending_high_byte_in = byte_count_ff[0] ? pending_high_byte_ff
                                                  : req_channel.data_byte;
   assign payload_sum_in = byte_count_ff[0]
                           ? ones_add(payload_sum_ff,
                                      {pending_high_byte_ff, req_channel.data_byte})
                           : payload_sum_ff;
   assign byte_count_in = (byte_count_ff == BYTE_COUNT_CAP) ? byte_count_ff
                                                            : byte_count_ff + 1'b1;

   assign length_bad = byte_count_in < COUNT_WIDTH'(MIN_PAYLOAD)
                    || byte_count_in > COUNT_WIDTH'(MAX_PAYLOAD)
                    || lead_word_in != {15'b0, byte_count_in};

   assign job_valid = accept && req_channel.last_byte;

   always_comb begin
      job.rejected     = length_bad;
      job.direction    = packet_direction_in;
      job.length       = byte_count_in[15:0];
      job.payload_sum  = payload_sum_in;
      job.pad_word     = byte_count_in[0] ? {pending_high_byte_in, 8'h00} : 16'h0;
      job.ident        = ident_ff;
      job.src_ip       = packet_direction_in ? server_address_ff : client_address_ff;
      job.dst_ip       = packet_direction_in ? client_address_ff : server_address_ff;
      job.src_tcp_port = packet_direction_in ? server_tcp_port_ff : client_tcp_port_ff;
      job.dst_tcp_port = packet_direction_in ? client_tcp_port_ff : server_tcp_port_ff;
      job.seq          = packet_direction_in ? server_seq_ff : client_seq_ff;
      job.ack          = packet_direction_in ? client_seq_ff : server_seq_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         client_address_ff    <= '0;
         server_address_ff    <= '0;
         client_tcp_port_ff   <= '0;
         server_tcp_port_ff   <= '0;
         client_seq_ff        <= CLIENT_SEQ_RESET;
         server_seq_ff        <= SERVER_SEQ_RESET;
         ident_ff             <= '0;
         byte_count_ff        <= '0;
         lead_word_ff         <= '0;
         payload_sum_ff       <= '0;
         pending_high_byte_ff <= '0;
         packet_direction_ff  <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            case (csr_index_type'(csr_index))
               CSR_CLIENT_ADDRESS:   client_address_ff  <= csr_write_data;
               CSR_SERVER_ADDRESS:   server_address_ff  <= csr_write_data;
               CSR_CLIENT_TCP_PORT:  client_tcp_port_ff <= csr_write_data[15:0];
               CSR_SERVER_TCP_PORT:  server_tcp_port_ff <= csr_write_data[15:0];
               CSR_CLIENT_SEQ_START: client_seq_ff      <= csr_write_data;
               CSR_SERVER_SEQ_START: server_seq_ff      <= csr_write_data;
               CSR_IDENT_START:      ident_ff           <= csr_write_data[15:0];
               default: ;
            endcase
         end else if (job_valid && !length_bad) begin
            ident_ff <= ident_ff + 1'b1;
            if (packet_direction_in) begin
               server_seq_ff <= server_seq_ff + {16'b0, byte_count_in[15:0]};
            end else begin
               client_seq_ff <= client_seq_ff + {16'b0, byte_count_in[15:0]};
            end
         end
         if (accept) begin
            packet_direction_ff <= packet_direction_in;
            if (req_channel.last_byte) begin
               byte_count_ff        <= '0;
               lead_word_ff         <= '0;
               payload_sum_ff       <= '0;
               pending_high_byte_ff <= '0;
            end else begin
               byte_count_ff        <= byte_count_in;
               lead_word_ff         <= lead_word_in;
               payload_sum_ff       <= payload_sum_in;
               pending_high_byte_ff <= pending_high_byte_in;
            end
         end
      end
   end

   tcphb_emit u_emit (
      .clock       (clock),
      .reset       (reset),
      .job_valid   (job_valid),
      .job         (job),
      .job_ready   (job_ready),
      .rsp_channel (rsp_channel)
   );

endmodule

// File: hw/rtl/tcphb_emit.sv
// Checksum pipeline and word sequencer that turns a packet job into header transactions.
module tcphb_emit import tcphb_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               job_valid,
   input  job_type            job,
   output logic               job_ready,
   tcphb_rsp_if.source        rsp_channel
);

   function automatic logic [15:0] fold20(input logic [19:0] s);
      logic [16:0] x;
      logic [15:0] y;
      x = {1'b0, s[15:0]} + {13'b0, s[19:16]};
      y = x[15:0] + {15'b0, x[16]};
      return y;
   endfunction

   logic                        job_valid_ff;
   job_type                     job_ff;
   logic                        sum_valid_ff;
   job_type                     sum_job_ff;
   logic [19:0]                 ip_sum_ff, ip_sum_in;
   logic [19:0]                 tcp_a_ff, tcp_a_in;
   logic [19:0]                 tcp_b_ff, tcp_b_in;
   logic                        out_valid_ff;
   job_type                     out_job_ff;
   logic [15:0]                 ip_csum_ff, ip_csum_in;
   logic [15:0]                 tcp_csum_ff, tcp_csum_in;
   logic [WORD_INDEX_WIDTH-1:0] word_index_ff;

   logic        out_fire, out_done, out_take, sum_take;
   logic [15:0] job_total_len, job_tcp_len, out_total_len;
   logic [7:0]  dst_mac_low, src_mac_low;
   logic [63:0] frame_words [WORD_COUNT];

   assign out_fire = out_valid_ff && rsp_channel.ready;
   assign out_done = out_fire && (out_job_ff.rejected || word_index_ff == LAST_WORD);
   assign out_take = !out_valid_ff || out_done;
   assign sum_take = !sum_valid_ff || out_take;
   assign job_ready = !job_valid_ff || sum_take;

   assign job_total_len = job_ff.length + IP_TOTAL_EXTRA;
   assign job_tcp_len   = job_ff.length + TCP_LEN_EXTRA;

   assign ip_sum_in = 20'(IP_VER_TOS) + 20'(job_total_len) + 20'(job_ff.ident)
                    + 20'(IP_FLAGS) + 20'(IP_TTL_PROTO)
                    + 20'(job_ff.src_ip[31:16]) + 20'(job_ff.src_ip[15:0])
                    + 20'(job_ff.dst_ip[31:16]) + 20'(job_ff.dst_ip[15:0]);

   assign tcp_a_in = 20'(job_ff.payload_sum) + 20'(job_ff.pad_word)
                   + 20'(job_ff.src_ip[31:16]) + 20'(job_ff.src_ip[15:0])
                   + 20'(job_ff.dst_ip[31:16]) + 20'(job_ff.dst_ip[15:0])
                   + 20'(TCP_PROTO) + 20'(job_tcp_len);

   assign tcp_b_in = 20'(job_ff.src_tcp_port) + 20'(job_ff.dst_tcp_port)
                   + 20'(job_ff.seq[31:16]) + 20'(job_ff.seq[15:0])
                   + 20'(job_ff.ack[31:16]) + 20'(job_ff.ack[15:0])
                   + 20'(TCP_OFF_FLAGS) + 20'(TCP_WINDOW);

   assign ip_csum_in  = ~fold20(ip_sum_ff);
   assign tcp_csum_in = ~fold20(tcp_a_ff + tcp_b_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         job_valid_ff  <= 1'b0;
         sum_valid_ff  <= 1'b0;
         out_valid_ff  <= 1'b0;
         word_index_ff <= '0;
      end else begin
         if (job_ready) begin
            job_valid_ff <= job_valid;
         end
         if (sum_take) begin
            sum_valid_ff <= job_valid_ff;
         end
         if (out_take) begin
            out_valid_ff  <= sum_valid_ff;
            word_index_ff <= '0;
         end else if (out_fire) begin
            word_index_ff <= word_index_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (job_ready && job_valid) begin
         job_ff <= job;
      end
      if (sum_take) begin
         sum_job_ff <= job_ff;
         ip_sum_ff  <= ip_sum_in;
         tcp_a_ff   <= tcp_a_in;
         tcp_b_ff   <= tcp_b_in;
      end
      if (out_take) begin
         out_job_ff  <= sum_job_ff;
         ip_csum_ff  <= ip_csum_in;
         tcp_csum_ff <= tcp_csum_in;
      end
   end

   assign out_total_len = out_job_ff.length + IP_TOTAL_EXTRA;
   assign dst_mac_low   = out_job_ff.direction ? MAC_CLIENT_LOW : MAC_SERVER_LOW;
   assign src_mac_low   = out_job_ff.direction ? MAC_SERVER_LOW : MAC_CLIENT_LOW;

   assign frame_words[0] = {MAC_PREFIX, dst_mac_low, MAC_PREFIX[39:24]};
   assign frame_words[1] = {MAC_PREFIX[23:0], src_mac_low, ETHER_TYPE_IPV4, IP_VER_TOS};
   assign frame_words[2] = {out_total_len, out_job_ff.ident, IP_FLAGS, IP_TTL_PROTO};
   assign frame_words[3] = {ip_csum_ff, out_job_ff.src_ip, out_job_ff.dst_ip[31:16]};
   assign frame_words[4] = {out_job_ff.dst_ip[15:0], out_job_ff.src_tcp_port,
                            out_job_ff.dst_tcp_port, out_job_ff.seq[31:16]};
   assign frame_words[5] = {out_job_ff.seq[15:0], out_job_ff.ack, TCP_OFF_FLAGS};
   assign frame_words[6] = {TCP_WINDOW, tcp_csum_ff, 32'h0};

   assign rsp_channel.valid       = out_valid_ff;
   assign rsp_channel.rejected    = out_job_ff.rejected;
   assign rsp_channel.word_last   = out_job_ff.rejected || word_index_ff == LAST_WORD;
   assign rsp_channel.header_word = out_job_ff.rejected ? 64'h0 : frame_words[word_index_ff];

endmodule

// File: tb/tb_tcp_ipv4_frame_header_builder.sv
// Self-checking testbench for the TCP/IPv4 frame header builder: directed and random packets.
module tb_tcp_ipv4_frame_header_builder import tcphb_pkg::*; ();

   localparam int STALL_LIMIT   = 2000;
   localparam int SETTLE_CYCLES = 12;
   localparam int RANDOM_BYTES  = 160;
   localparam int RANDOM_PHASES = 4;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_UNUSED_INDEX = 3'd7;

   localparam logic [47:0] CLIENT_MAC   = 48'h02_00_00_00_00_01;
   localparam logic [47:0] SERVER_MAC   = 48'h02_00_00_00_00_02;
   localparam logic [15:0] ETHER_IPV4   = 16'h0800;
   localparam logic [15:0] IP_VER_IHL   = 16'h4500;
   localparam logic [15:0] IP_DONT_FRAG = 16'h4000;
   localparam logic [15:0] IP_TTL_TCP   = 16'h4006;
   localparam logic [15:0] PROTO_TCP    = 16'h0006;
   localparam logic [15:0] TCP_HDR_PSH  = 16'h5018;
   localparam logic [15:0] TCP_WIN_MAX  = 16'hffff;

   typedef enum logic [1:0] {
      FILL_ZERO,
      FILL_ONES,
      FILL_RANDOM
   } fill_kind_type;

   typedef struct packed {
      logic [1:0]    phase;
      logic          dir;
      logic [16:0]   len;
      logic [31:0]   lead;
      fill_kind_type fill;
      logic          typed_reject;
   } packet_row_type;

   typedef struct packed {
      logic [31:0] client_address;
      logic [31:0] server_address;
      logic [31:0] client_tcp_port;
      logic [31:0] server_tcp_port;
      logic [31:0] client_seq_start;
      logic [31:0] server_seq_start;
      logic [31:0] ident_start;
   } settings_type;

   typedef struct packed {
      logic [63:0] header_word;
      logic        rejected;
      logic        word_last;
   } header_result_type;

   localparam packet_row_type DIRECTED_ROWS [0:11] = '{
      '{2'd0, 1'b0, 17'd8,     32'd8,          FILL_ZERO,   1'b0},
      '{2'd0, 1'b1, 17'd9,     32'd9,          FILL_ONES,   1'b0},
      '{2'd0, 1'b0, 17'd1,     32'h0100_0000,  FILL_RANDOM, 1'b1},
      '{2'd0, 1'b1, 17'd7,     32'd7,          FILL_RANDOM, 1'b1},
      '{2'd0, 1'b0, 17'd12,    32'd13,         FILL_RANDOM, 1'b1},
      '{2'd0, 1'b1, 17'd10,    32'd10,         FILL_RANDOM, 1'b0},
      '{2'd1, 1'b0, 17'd8,     32'd8,          FILL_ONES,   1'b0},
      '{2'd1, 1'b1, 17'd16,    32'd16,         FILL_ZERO,   1'b0},
      '{2'd1, 1'b1, 17'd9,     32'h8000_0009,  FILL_RANDOM, 1'b1},
      '{2'd1, 1'b0, 17'd11,    32'd11,         FILL_RANDOM, 1'b0},
      '{2'd2, 1'b1, 17'd8,     32'd8,          FILL_ZERO,   1'b0},
      '{2'd2, 1'b0, 17'd13,    32'd13,         FILL_ONES,   1'b0}
   };

   localparam settings_type DIRECTED_SETTINGS [1:2] = '{
      '{32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
        32'hffff_fff8, 32'hffff_ffff, 32'h0000_ffff},
      '{32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0}
   };

   logic                       clock;
   logic                       reset;
   logic                       csr_write_enable;
   logic [CSR_INDEX_WIDTH-1:0] csr_index;
   logic [CSR_DATA_WIDTH-1:0]  csr_write_data;

   tcphb_req_if req_bus ();
   tcphb_rsp_if rsp_bus ();

   tcp_ipv4_frame_header_builder u_top (
      .clock            (clock),
      .reset            (reset),
      .req_channel      (req_bus),
      .rsp_channel      (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // predictor state
   logic [31:0] client_addr, server_addr;
   logic [15:0] client_tcp_port, server_tcp_port;
   logic [31:0] client_seq, server_seq;
   logic [15:0] ident_counter;
   logic [16:0] byte_count;
   logic [31:0] lead_word;
   logic [15:0] payload_sum;
   logic [7:0]  pending_high;
   logic        packet_dir;

   header_result_type expected_headers [$];
   header_result_type packet_results [$];

   int failures;
   int bytes_sent;
   int headers_built;
   int packets_rejected;
   int words_checked;
   int settings_loaded;
   int stall_cycles;
   int sender_burst;
   int receiver_burst;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic logic [15:0] fold_add(input logic [15:0] a, input logic [15:0] b);
      logic [16:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[15:0] + {15'b0, s[16]};
   endfunction

   function automatic logic [15:0] fold_words(input logic [15:0] acc, input logic [159:0] words);
      for (int i = 0; i < 10; i++)
         acc = fold_add(acc, words[159 - 16*i -: 16]);
      return acc;
   endfunction

   function automatic int draw_gap(inout int burst_left);
      if (burst_left > 0) begin
         burst_left--;
         return 0;
      end
      if ($urandom_range(0, 15) == 0) begin
         burst_left = $urandom_range(8, 48);
         return 0;
      end
      return $urandom_range(0, 16);
   endfunction

   task automatic clear_packet_state();
      byte_count   = '0;
      lead_word    = '0;
      payload_sum  = '0;
      pending_high = '0;
   endtask

   task automatic load_register(input logic [CSR_INDEX_WIDTH-1:0] idx, input logic [31:0] value);
      case (csr_index_type'(idx))
         CSR_CLIENT_ADDRESS:   client_addr = value;
         CSR_SERVER_ADDRESS:   server_addr = value;
         CSR_CLIENT_TCP_PORT:  client_tcp_port = value[15:0];
         CSR_SERVER_TCP_PORT:  server_tcp_port = value[15:0];
         CSR_CLIENT_SEQ_START: client_seq = value;
         CSR_SERVER_SEQ_START: server_seq = value;
         CSR_IDENT_START:      ident_counter = value[15:0];
         default: ;
      endcase
   endtask

   task automatic absorb_payload_byte(input logic dir, input logic [7:0] data, input logic last);
      logic [16:0]  len;
      logic [15:0]  psum, csum, ip_check, tcp_check;
      logic [31:0]  src_ip, dst_ip, seq, ack;
      logic [15:0]  src_tcp_port, dst_tcp_port;
      logic [159:0] ip_words, tcp_words;
      logic [447:0] frame;
      packet_results.delete();
      if (byte_count == 0)
         packet_dir = dir;
      if (byte_count < 4)
         lead_word = {lead_word[23:0], data};
      if (!byte_count[0])
         pending_high = data;
      else
         payload_sum = fold_add(payload_sum, {pending_high, data});
      if (byte_count < 17'h1_0000)
         byte_count++;
      if (!last)
         return;
      len = byte_count;
      psum = payload_sum;
      if (len[0])
         psum = fold_add(psum, {pending_high, 8'h00});
      if (len < 8 || len > 17'd65535 || lead_word != {15'b0, len}) begin
         packet_results.push_back('{64'h0, 1'b1, 1'b1});
         clear_packet_state();
         return;
      end
      src_ip       = packet_dir ? server_addr : client_addr;
      dst_ip       = packet_dir ? client_addr : server_addr;
      src_tcp_port = packet_dir ? server_tcp_port : client_tcp_port;
      dst_tcp_port = packet_dir ? client_tcp_port : server_tcp_port;
      seq          = packet_dir ? server_seq : client_seq;
      ack          = packet_dir ? client_seq : server_seq;

      ip_words = {IP_VER_IHL, len[15:0] + 16'd40, ident_counter, IP_DONT_FRAG, IP_TTL_TCP,
                  16'h0000, src_ip, dst_ip};
      ip_check = ~fold_words(16'h0, ip_words);

      tcp_words = {src_tcp_port, dst_tcp_port, seq, ack, TCP_HDR_PSH, TCP_WIN_MAX,
                   16'h0, 16'h0};
      csum = fold_add(psum, src_ip[31:16]);
      csum = fold_add(csum, src_ip[15:0]);
      csum = fold_add(csum, dst_ip[31:16]);
      csum = fold_add(csum, dst_ip[15:0]);
      csum = fold_add(csum, PROTO_TCP);
      csum = fold_add(csum, len[15:0] + 16'd20);
      tcp_check = ~fold_words(csum, tcp_words);

      frame = {packet_dir ? CLIENT_MAC : SERVER_MAC, packet_dir ? SERVER_MAC : CLIENT_MAC,
               ETHER_IPV4, ip_words[159:80], ip_check, ip_words[63:0],
               tcp_words[159:32], tcp_check, 16'h0, 16'h0};
      for (int k = 0; k < 7; k++)
         packet_results.push_back('{frame[447 - 64*k -: 64], 1'b0, k == 6});

      ident_counter++;
      if (packet_dir)
         server_seq = server_seq + {15'b0, len};
      else
         client_seq = client_seq + {15'b0, len};
      clear_packet_state();
   endtask

   task automatic send_byte(input logic dir, input logic [7:0] data, input logic last);
      int gap;
      gap = draw_gap(sender_burst);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.to_client <= dir;
      req_bus.data_byte <= data;
      req_bus.last_byte <= last;
      do @(posedge clock); while (!req_bus.ready);
      absorb_payload_byte(dir, data, last);
      bytes_sent++;
   endtask

   task automatic run_packet(input logic dir, input int len, input logic [31:0] lead,
                             input fill_kind_type fill, input logic typed_reject);
      logic [7:0] data;
      for (int i = 0; i < len; i++) begin
         if (i < 4)
            data = lead[31 - 8*i -: 8];
         else if (fill == FILL_ZERO)
            data = 8'h00;
         else if (fill == FILL_ONES)
            data = 8'hff;
         else
            data = 8'($urandom_range(0, 255));
         send_byte(i == 0 ? dir : 1'($urandom_range(0, 1)), data, i == len - 1);
      end
      if (typed_reject) begin
         expected_headers.push_back('{64'h0, 1'b1, 1'b1});
      end else begin
         foreach (packet_results[k])
            expected_headers.push_back(packet_results[k]);
      end
      if (packet_results.size() > 1)
         headers_built++;
      else
         packets_rejected++;
   endtask

   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      while (expected_headers.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_INDEX_WIDTH-1:0] idx, input logic [31:0] value);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= value;
      @(posedge clock);
      load_register(idx, value);
   endtask

   task automatic apply_settings(input settings_type s);
      write_register(CSR_CLIENT_ADDRESS, s.client_address);
      write_register(CSR_SERVER_ADDRESS, s.server_address);
      write_register(CSR_CLIENT_TCP_PORT, s.client_tcp_port);
      write_register(CSR_SERVER_TCP_PORT, s.server_tcp_port);
      write_register(CSR_CLIENT_SEQ_START, s.client_seq_start);
      write_register(CSR_SERVER_SEQ_START, s.server_seq_start);
      write_register(CSR_IDENT_START, s.ident_start);
      write_register(CSR_UNUSED_INDEX, $urandom());
      csr_write_enable <= 1'b0;
      settings_loaded++;
   endtask

   function automatic logic [31:0] random_field();
      case ($urandom_range(0, 5))
         0:       return 32'h0;
         1:       return 32'hffff_ffff;
         2:       return 32'hffff_ffff - $urandom_range(0, 300);
         default: return $urandom();
      endcase
   endfunction

   function automatic settings_type random_settings();
      settings_type s;
      s.client_address   = random_field();
      s.server_address   = random_field();
      s.client_tcp_port  = random_field();
      s.server_tcp_port  = random_field();
      s.client_seq_start = random_field();
      s.server_seq_start = random_field();
      s.ident_start      = random_field();
      return s;
   endfunction

   task automatic run_random_packet();
      logic          dir;
      int            len;
      logic [31:0]   lead;
      fill_kind_type fill;
      int            kind;
      kind = $urandom_range(0, 9);
      dir  = 1'($urandom_range(0, 1));
      if ($urandom_range(0, 7) == 0)
         fill = $urandom_range(0, 1) ? FILL_ONES : FILL_ZERO;
      else
         fill = FILL_RANDOM;
      if (kind == 0) begin
         len  = $urandom_range(1, 7);
         lead = $urandom_range(0, 1) ? 32'(len) : $urandom();
      end else begin
         len  = ($urandom_range(0, 19) == 0) ? $urandom_range(25, 48) : $urandom_range(8, 24);
         lead = 32'(len);
         if (kind == 1)
            lead = $urandom_range(0, 1) ? lead ^ (32'h1 << $urandom_range(0, 31)) : $urandom();
      end
      run_packet(dir, len, lead, fill, 1'b0);
   endtask

   // result side: random stalls, compare against the oldest expectation
   initial begin
      int gap;
      header_result_type want;
      rsp_bus.ready <= 1'b0;
      @(posedge clock);
      while (reset)
         @(posedge clock);
      forever begin
         gap = draw_gap(receiver_burst);
         if (gap > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!rsp_bus.valid);
         words_checked++;
         if (expected_headers.size() == 0) begin
            $error("unexpected transaction: header_word %h rejected %b word_last %b",
                   rsp_bus.header_word, rsp_bus.rejected, rsp_bus.word_last);
            failures++;
         end else begin
            want = expected_headers.pop_front();
            if (rsp_bus.header_word !== want.header_word) begin
               $error("header_word expected %h actual %h", want.header_word, rsp_bus.header_word);
               failures++;
            end
            if (rsp_bus.rejected !== want.rejected) begin
               $error("rejected expected %b actual %b", want.rejected, rsp_bus.rejected);
               failures++;
            end
            if (rsp_bus.word_last !== want.word_last) begin
               $error("word_last expected %b actual %b", want.word_last, rsp_bus.word_last);
               failures++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)
          || csr_write_enable) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   initial begin
      int phase;
      int random_start;
      reset             <= 1'b1;
      req_bus.valid     <= 1'b0;
      req_bus.to_client <= 1'b0;
      req_bus.data_byte <= 8'h00;
      req_bus.last_byte <= 1'b0;
      csr_write_enable  <= 1'b0;
      csr_index         <= CSR_CLIENT_ADDRESS;
      csr_write_data    <= '0;
      stall_cycles      = 0;
      failures          = 0;
      bytes_sent        = 0;
      headers_built     = 0;
      packets_rejected  = 0;
      words_checked     = 0;
      settings_loaded   = 0;
      sender_burst      = 0;
      receiver_burst    = 0;

      client_addr     = '0;
      server_addr     = '0;
      client_tcp_port = '0;
      server_tcp_port = '0;
      client_seq      = 32'd1000;
      server_seq      = 32'd500000;
      ident_counter   = '0;
      packet_dir      = 1'b0;
      clear_packet_state();

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      phase = 0;
      foreach (DIRECTED_ROWS[r]) begin
         if (int'(DIRECTED_ROWS[r].phase) != phase) begin
            wait_drained();
            phase = DIRECTED_ROWS[r].phase;
            apply_settings(DIRECTED_SETTINGS[phase]);
         end
         run_packet(DIRECTED_ROWS[r].dir, DIRECTED_ROWS[r].len, DIRECTED_ROWS[r].lead,
                    DIRECTED_ROWS[r].fill, DIRECTED_ROWS[r].typed_reject);
      end

      random_start = bytes_sent;
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         wait_drained();
         apply_settings(random_settings());
         while (bytes_sent - random_start < (p + 1) * RANDOM_BYTES / RANDOM_PHASES) begin
            run_random_packet();
            if ($urandom_range(0, 7) == 0)
               wait_drained();
         end
      end
      wait_drained();

      $display("Sent %0d payload bytes: %0d packets built headers, %0d were rejected.",
               bytes_sent, headers_built, packets_rejected);
      $display("Checked %0d result transactions under %0d register settings.",
               words_checked, settings_loaded);
      if (failures == 0 && expected_headers.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
